[sv/drs_pkg.sv]
package drs_pkg;

  localparam int QueueDepth = 16;
  localparam int SlotW      = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int ReqW       = 16 + 32 + 16 + 32 + 16;

  localparam logic [1:0] PolFcfs = 2'd0;
  localparam logic [1:0] PolSstf = 2'd1;
  localparam logic [1:0] PolLook = 2'd2;

  localparam logic FuncArrive   = 1'b0;
  localparam logic FuncComplete = 1'b1;

  // scan pass class
  typedef enum logic [1:0] {
    SEL_EXACT = 2'd0,
    SEL_DIR   = 2'd1,
    SEL_ALL   = 2'd2
  } sel_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] cylinder;
    logic [31:0] address;
    logic [15:0] process;
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic             load_in;
    logic             do_arrive;
    logic             scan_clear;
    logic             scan_step;
    logic [SlotW-1:0] scan_idx;
    sel_e             sel;
    logic             take_best;
    logic             shift_step;
    logic [SlotW-1:0] shift_idx;
    logic             done_shift;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              func;
    logic              found;
    logic [SlotW-1:0]  best_idx;
    logic [CountW-1:0] count;
    logic [1:0]        policy;
  } dp_sts_t;

endpackage

[sv/drs_datapath.sv]
module drs_datapath
  import drs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_data_i,
  input  logic [135:0]      in_data_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output req_t              svc_o,
  output logic [CountW-1:0] count_o,
  output logic              dropped_o
);

  // queue storage, one flop row per slot
  req_t              mem_q [QueueDepth];
  logic [CountW-1:0] count_q;
  req_t              serv_q;
  logic              drop_q;
  logic [1:0]        pol_q;

  // latched input beat
  logic        func_q;
  req_t        new_q;
  logic [15:0] head_q;
  logic        up_q;

  // best candidate so far
  logic             found_q;
  logic [SlotW-1:0] best_q;
  logic [15:0]      bd_q;
  logic [31:0]      ba_q;

  // current scan candidate
  req_t        cand;
  logic [15:0] seek_dist;
  logic        match;
  logic        better;
  logic        full;

  assign cand = mem_q[cmd_i.scan_idx];
  assign full = (count_q == CountW'(QueueDepth));

  always_comb begin
    seek_dist = (cand.cylinder > head_q) ? cand.cylinder - head_q
                                         : head_q - cand.cylinder;
    if (pol_q == PolFcfs || pol_q == 2'd3) begin
      seek_dist = '0;
    end
    case (cmd_i.sel)
      SEL_EXACT: match = (cand.cylinder == head_q);
      SEL_DIR:   match = up_q ? (cand.cylinder > head_q) : (cand.cylinder < head_q);
      default:   match = 1'b1;
    endcase
    better = !found_q || (seek_dist < bd_q) ||
             ((seek_dist == bd_q) && (cand.arrival < ba_q));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      serv_q  <= '0;
      drop_q  <= 1'b0;
      pol_q   <= PolFcfs;
      found_q <= 1'b0;
      func_q  <= FuncArrive;
    end else begin
      if (cfg_valid_i) begin
        pol_q <= cfg_data_i;
      end
      if (cmd_i.load_in) begin
        func_q <= in_data_i[0];
        drop_q <= 1'b0;
      end
      if (cmd_i.do_arrive) begin
        if (serv_q.id == '0) begin
          serv_q <= new_q;
        end else if (!full) begin
          count_q <= count_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.scan_clear) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && match && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.take_best) begin
        serv_q <= found_q ? mem_q[best_q] : '0;
      end
      if (cmd_i.done_shift) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      new_q.id       <= in_data_i[16:1];
      new_q.arrival  <= in_data_i[48:17];
      new_q.cylinder <= in_data_i[64:49];
      new_q.address  <= in_data_i[96:65];
      new_q.process  <= in_data_i[112:97];
      head_q         <= in_data_i[128:113];
      up_q           <= in_data_i[129];
    end
    if (cmd_i.do_arrive && serv_q.id != '0 && !full) begin
      mem_q[count_q[SlotW-1:0]] <= new_q;
    end
    if (cmd_i.scan_step && match && better) begin
      best_q <= cmd_i.scan_idx;
      bd_q   <= seek_dist;
      ba_q   <= cand.arrival;
    end
    if (cmd_i.shift_step) begin
      mem_q[cmd_i.shift_idx] <= mem_q[cmd_i.shift_idx + 1'b1];
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.found    = found_q;
  assign sts_o.best_idx = best_q;
  assign sts_o.count    = count_q;
  assign sts_o.policy   = pol_q;
  assign svc_o          = serv_q;
  assign count_o        = count_q;
  assign dropped_o      = drop_q;

endmodule

[sv/drs_ctrl.sv]
module drs_ctrl
  import drs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_NEXT   = 6'b001000,
    ST_SHIFT  = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] idx_q, idx_d;
  sel_e              sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      sel_q   <= SEL_ALL;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    cmd_o       = '0;
    cmd_o.sel   = sel_q;
    cmd_o.scan_idx  = idx_q[SlotW-1:0];
    cmd_o.shift_idx = idx_q[SlotW-1:0];
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.func == FuncArrive) begin
          cmd_o.do_arrive = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.scan_clear = 1'b1;
          idx_d = '0;
          sel_d = (sts_i.policy == PolLook) ? SEL_EXACT : SEL_ALL;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < sts_i.count) begin
          cmd_o.scan_step = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!sts_i.found && sel_q != SEL_ALL) begin
          sel_d = (sel_q == SEL_EXACT) ? SEL_DIR : SEL_ALL;
          idx_d = '0;
          state_d = ST_SCAN;
        end else begin
          cmd_o.take_best = 1'b1;
          idx_d = {1'b0, sts_i.best_idx};
          state_d = sts_i.found ? ST_SHIFT : ST_OUT;
        end
      end
      ST_SHIFT: begin
        if (idx_q + 1'b1 < sts_i.count) begin
          cmd_o.shift_step = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          cmd_o.done_shift = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/disk_request_scheduler_top.sv]
// an arrival is handled without a scan; a completion is set by the one-slot-per-cycle
// queue scan plus one decision step per pass (up to three passes for look) and the
// one-slot-per-cycle compaction of the queue one item at a time; the next beat is
// taken after the result beat leaves
// reset clears the queue count, the request in service and the policy (fcfs)
module disk_request_scheduler_top
  import drs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i,      // policy
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func, new_id, new_arrival, new_cylinder, new_address, new_process,
  // head_cylinder, scan_up, zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // svc_id, svc_arrival, svc_cylinder, svc_address, svc_process,
  // pending_count, dropped, zero fill
  output logic [119:0] m_axis_tdata
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  req_t              svc;
  logic [CountW-1:0] cnt;
  logic              drop;

  assign cfg_ready_o = 1'b1;

  drs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .svc_o       (svc),
    .count_o     (cnt),
    .dropped_o   (drop)
  );

  assign m_axis_tdata = {2'b00, drop, cnt, svc.process, svc.address, svc.cylinder,
                         svc.arrival, svc.id};

endmodule
